[design/ctet_pkg.sv]
// ctet_pkg: beat types, event kind codes, register indexes and state encoding
// for the contact enter/stay/exit tracker; no dependencies
package ctet_pkg;

    localparam int KEY_W  = 16;
    localparam int KIND_W = 3;

    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] object_key;
        logic             is_dynamic;
        logic             has_tag;
    } in_beat_t;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [KEY_W-1:0]  event_key;
        logic              last;
    } out_beat_t;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ENTER = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STAY  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EXIT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FULL  = 3'd4;

    // input func codes
    localparam logic FUNC_HIT   = 1'b0;
    localparam logic FUNC_SWEEP = 1'b1;

    // configuration register indexes
    localparam logic CFG_ACTIVE  = 1'b0;
    localparam logic CFG_OWN_KEY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP,
        ST_SWEEP_RD,
        ST_EMIT
    } state_t;

endpackage

[design/contact_enter_stay_exit_tracker.sv]
// contact_enter_stay_exit_tracker: top level, key memory with sequential scan
// depends on ctet_pkg
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------
//  in      | in        | in_valid / in_stall    | ctet_pkg::in_beat_t
//  out     | out       | out_valid / out_stall  | ctet_pkg::out_beat_t
//  cfg     | in        | cfg_we                 | cfg_index, cfg_data
//
// an item that makes no result (tracker inactive, over hit budget, filtered)
// is taken in ST_IDLE and dropped there. a hit report that reaches the table
// is compared against the key memory, which has one read port and is scanned
// one entry per cycle, then the result goes to the output register; a stay
// ends once its entry is compared. a sweep walks the table through the same
// read port, each exit beat going through ST_SWEEP_RD and ST_EMIT. reset
// clears valid and seen bits at once, no clearing pass.
// out_stall holds the output register and the result waiting for it; in_stall
// is high while an item is in work, including while its results wait.
module contact_enter_stay_exit_tracker #(
    parameter int TABLE_ENTRIES  = 16,
    parameter int HITS_PER_FRAME = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  ctet_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ctet_pkg::out_beat_t out_data
);
    import ctet_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int HIT_W = $clog2(HITS_PER_FRAME + 1);

    localparam logic [CNT_W-1:0] CNT_END   = CNT_W'(TABLE_ENTRIES);
    localparam logic [HIT_W-1:0] HIT_LIMIT = HIT_W'(HITS_PER_FRAME);

    // configuration
    logic             active_reg;
    logic [KEY_W-1:0] own_key_reg;

    // control state
    state_t                   state_reg, state_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [TABLE_ENTRIES-1:0] seen_reg, seen_next;
    logic [HIT_W-1:0]         hits_reg, hits_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic                     chk_reg, chk_next;
    logic [IDX_W-1:0]         chk_idx_reg, chk_idx_next;
    logic                     free_found_reg, free_found_next;
    logic [IDX_W-1:0]         free_idx_reg, free_idx_next;
    logic                     ret_sweep_reg, ret_sweep_next;
    logic                     out_valid_reg, out_valid_next;

    // payload
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [KIND_W-1:0] res_kind_reg, res_kind_next;
    logic [KEY_W-1:0]  res_key_reg, res_key_next;
    logic              res_last_reg, res_last_next;
    out_beat_t         out_data_reg, out_data_next;

    // key memory
    logic [KEY_W-1:0] key_mem [TABLE_ENTRIES];
    logic [KEY_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;

    logic in_accept;
    logic out_free;
    logic chk_valid;
    logic match;
    logic filtered;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign chk_valid = valid_reg[chk_idx_reg];
    assign match     = chk_reg && chk_valid && (rd_data_reg == key_reg);
    assign filtered  = (in_data.object_key == own_key_reg) || in_data.is_dynamic
                       || !in_data.has_tag;

    // key memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_waddr] <= key_reg;
        end
        rd_data_reg <= key_mem[rd_addr];
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            own_key_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ACTIVE:  active_reg  <= cfg_data[0];
                CFG_OWN_KEY: own_key_reg <= cfg_data;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            seen_reg       <= '0;
            hits_reg       <= '0;
            idx_reg        <= '0;
            chk_reg        <= 1'b0;
            chk_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            ret_sweep_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            seen_reg       <= seen_next;
            hits_reg       <= hits_next;
            idx_reg        <= idx_next;
            chk_reg        <= chk_next;
            chk_idx_reg    <= chk_idx_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            ret_sweep_reg  <= ret_sweep_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        res_kind_reg <= res_kind_next;
        res_key_reg  <= res_key_next;
        res_last_reg <= res_last_next;
        out_data_reg <= out_data_next;
    end

    // next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        seen_next       = seen_reg;
        hits_next       = hits_reg;
        idx_next        = idx_reg;
        chk_next        = 1'b0;
        chk_idx_next    = chk_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        ret_sweep_next  = ret_sweep_reg;
        key_next        = key_reg;
        res_kind_next   = res_kind_reg;
        res_key_next    = res_key_reg;
        res_last_next   = res_last_reg;
        out_data_next   = out_data_reg;
        rd_addr         = idx_reg[IDX_W-1:0];
        mem_we          = 1'b0;
        mem_waddr       = free_idx_reg;

        // output register drains independently of the item in work
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && active_reg)
                begin
                    key_next = in_data.object_key;
                    idx_next = '0;
                    if (in_data.func == FUNC_SWEEP)
                    begin
                        state_next = ST_SWEEP;
                    end
                    else if (hits_reg < HIT_LIMIT)
                    begin
                        hits_next = hits_reg + 1'b1;
                        if (!filtered)
                        begin
                            free_found_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                // compare entry read last cycle, issue next read
                ret_sweep_next = 1'b0;
                res_key_next   = key_reg;
                res_last_next  = 1'b1;
                if (match)
                begin
                    seen_next[chk_idx_reg] = 1'b1;
                    res_kind_next          = KIND_STAY;
                    state_next             = ST_EMIT;
                end
                else
                begin
                    if (chk_reg && !chk_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                    if (idx_reg < CNT_END)
                    begin
                        rd_addr      = idx_reg[IDX_W-1:0];
                        chk_next     = 1'b1;
                        chk_idx_next = idx_reg[IDX_W-1:0];
                        idx_next     = idx_reg + 1'b1;
                    end
                    else
                    begin
                        // whole table checked, no match: insert or flag full
                        state_next = ST_EMIT;
                        if (free_found_reg || (chk_reg && !chk_valid))
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = free_found_reg ? free_idx_reg : chk_idx_reg;
                            valid_next[mem_waddr] = 1'b1;
                            seen_next[mem_waddr]  = 1'b1;
                            res_kind_next         = KIND_ENTER;
                        end
                        else
                        begin
                            res_kind_next = KIND_FULL;
                        end
                    end
                end
            end

            ST_SWEEP:
            begin
                if (idx_reg < CNT_END)
                begin
                    if (valid_reg[idx_reg[IDX_W-1:0]])
                    begin
                        if (seen_reg[idx_reg[IDX_W-1:0]])
                        begin
                            seen_next[idx_reg[IDX_W-1:0]] = 1'b0;
                            idx_next = idx_reg + 1'b1;
                        end
                        else
                        begin
                            // fetch the key of the leaving object
                            rd_addr    = idx_reg[IDX_W-1:0];
                            state_next = ST_SWEEP_RD;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    // closing marker
                    hits_next      = '0;
                    res_kind_next  = KIND_NONE;
                    res_key_next   = '0;
                    res_last_next  = 1'b1;
                    ret_sweep_next = 1'b0;
                    state_next     = ST_EMIT;
                end
            end

            ST_SWEEP_RD:
            begin
                valid_next[idx_reg[IDX_W-1:0]] = 1'b0;
                idx_next       = idx_reg + 1'b1;
                res_kind_next  = KIND_EXIT;
                res_key_next   = rd_data_reg;
                res_last_next  = 1'b0;
                ret_sweep_next = 1'b1;
                state_next     = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.event_kind = res_kind_reg;
                    out_data_next.event_key  = res_key_reg;
                    out_data_next.last       = res_last_reg;
                    state_next = ret_sweep_reg ? ST_SWEEP : ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
